// ===== design/sdg_pkg.sv =====
// Shared constants, types and the gain/saturation function for the stereo delay block.
// Used by stereo_delay_and_gain; no dependencies of its own.
package sdg_pkg;

    // Frame memory depth in frames and the derived address width.
    localparam int DELAY_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);

    // Field and register widths.
    localparam int SAMPLE_W   = 24;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 1;

    // Width used for the read address arithmetic; it must hold the depth itself.
    localparam int CALC_W = (ADDR_W + 1 > DELAY_W) ? ADDR_W + 1 : DELAY_W;
    localparam logic [CALC_W-1:0] DEPTH_C = CALC_W'(DELAY_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [DELAY_W-1:0] DELAY_RESET = '0;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;

    // Gain arithmetic: 24 x 17 signed product, Q2.14 rounding, 27-bit quotient.
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
    localparam int ROUND_SHIFT = 14;
    localparam int QUOT_W      = PROD_W - ROUND_SHIFT;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;

    // Scale a sample by an unsigned Q2.14 gain, round half up and saturate to 24 bits.
    function automatic sample_t scale_sat(input sample_t s, input gain_t g);
        logic signed [PROD_W-1:0] prod;
        logic signed [QUOT_W-1:0] quot;
        sample_t                  res;
        prod = s * $signed({1'b0, g});
        prod = prod + PROD_W'(1 << (ROUND_SHIFT - 1));
        quot = QUOT_W'(prod >>> ROUND_SHIFT);
        if (quot > QUOT_W'(8388607)) begin
            res = 24'sh7FFFFF;
        end else if (quot < -QUOT_W'(8388608)) begin
            res = 24'sh800000;
        end else begin
            res = SAMPLE_W'(quot);
        end
        return res;
    endfunction

endpackage

// ===== design/stereo_delay_and_gain.sv =====
// Stereo delay line with output gain: accepts one stereo frame per cycle while the output is
// not stalled, and returns one result per frame through the stage 1 and output registers.
// The pace is set by the frame memory, which takes one write and one read each cycle.
// Entries never written since reset read as zero: the write pointer and a wrap flag
// tell which entries hold data, so no clearing pass runs after reset.
// Depends on sdg_pkg and sdg_ram.
module stereo_delay_and_gain
    import sdg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input frames.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [FRAME_W-1:0]    s_tdata,   // [23:0] left_in, [47:24] right_in
    input  logic                  s_tlast,   // block_end_in
    // Result frames.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [FRAME_W-1:0]    m_tdata,   // [23:0] left_out, [47:24] right_out
    output logic                  m_tlast    // block_end_out
);

    logic [DELAY_W-1:0] delay_reg;
    gain_t              gain_reg;
    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  wp_next;
    logic               full_reg;

    logic               s1_valid_reg;
    logic               s1_delayed_reg;
    logic               s1_hit_reg;
    logic [FRAME_W-1:0] s1_frame_reg;
    logic               s1_last_reg;

    logic               m_valid_reg;
    sample_t            m_left_reg;
    sample_t            m_right_reg;
    logic               m_last_reg;

    logic               s_accept;
    logic               s1_advance;
    logic               delay_nz;
    logic [CALC_W-1:0]  delay_ext;
    logic [CALC_W-1:0]  delay_clamp;
    logic [CALC_W-1:0]  wp_ext;
    logic [CALC_W-1:0]  rd_calc;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_hit;
    logic [FRAME_W-1:0] ram_rd_data;
    logic [FRAME_W-1:0] s1_sel_frame;
    sample_t            left_scaled;
    sample_t            right_scaled;

    // Pipeline flow control: stage 1 moves on when the output register is free.
    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
            gain_reg  <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DELAY_FRAMES: delay_reg <= DELAY_W'(cfg_wdata);
                REG_GAIN:         gain_reg  <= GAIN_W'(cfg_wdata);
                default:          ;
            endcase
        end
    end

    // Read address: delay clamped to the depth, taken back from the write pointer.
    assign delay_nz    = (delay_reg != '0);
    assign delay_ext   = CALC_W'(delay_reg);
    assign wp_ext      = CALC_W'(wp_reg);
    assign delay_clamp = (delay_ext > DEPTH_C) ? DEPTH_C : delay_ext;
    assign rd_calc     = (wp_ext >= delay_clamp) ? (wp_ext - delay_clamp)
                                                 : (wp_ext + DEPTH_C - delay_clamp);
    assign rd_addr     = rd_calc[ADDR_W-1:0];

    // Entries below the write pointer, or all of them once it has wrapped, hold data.
    assign rd_hit  = full_reg || (rd_addr < wp_reg);
    assign wp_next = (wp_reg == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_reg + ADDR_W'(1);

    // Write pointer and wrap flag advance on each delayed transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end else if (s_accept && delay_nz) begin
            wp_reg <= wp_next;
            if (wp_next == '0) begin
                full_reg <= 1'b1;
            end
        end
    end

    sdg_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DELAY_DEPTH)
    ) u_frame_ram (
        .clk     (aclk),
        .wr_en   (s_accept && delay_nz),
        .wr_addr (wp_reg),
        .wr_data (s_tdata),
        .rd_en   (s_accept && delay_nz),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Stage 1 control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Stage 1 payload: bypass frame and how to pick the result frame.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_delayed_reg <= delay_nz;
            s1_hit_reg     <= rd_hit;
            s1_frame_reg   <= s_tdata;
            s1_last_reg    <= s_tlast;
        end
    end

    // Pick the delayed or bypass frame, then apply gain with saturation.
    assign s1_sel_frame = !s1_delayed_reg ? s1_frame_reg :
                          (s1_hit_reg ? ram_rd_data : '0);
    assign left_scaled  = scale_sat(sample_t'(s1_sel_frame[SAMPLE_W-1:0]), gain_reg);
    assign right_scaled = scale_sat(sample_t'(s1_sel_frame[FRAME_W-1:SAMPLE_W]), gain_reg);

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_left_reg  <= left_scaled;
            m_right_reg <= right_scaled;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_right_reg, m_left_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // The write pointer moves only after a delayed input transfer.
    a_wp_moves_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg != $past(wp_reg)) |-> $past(s_accept && delay_nz))
        else $error("write pointer moved without a delayed transfer");

    // Once the memory has wrapped, only reset clears the wrap flag.
    a_full_sticky: assert property (@(posedge aclk)
        $fell(full_reg) |-> $past(!aresetn))
        else $error("wrap flag cleared outside reset");

    // Stage 1 holds its frame while the output register is stalled.
    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_tready) |=>
        (s1_valid_reg && $stable(s1_frame_reg) && $stable(s1_last_reg)))
        else $error("stage 1 changed while stalled");
`endif

endmodule

// ===== design/sdg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read and a write to the same address in one cycle return the old contents.
// No dependencies.
module sdg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read before write; read data holds when no read is issued.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the stereo delay line with output gain.
// Needs sdg_pkg and stereo_delay_and_gain; an internal delay-and-gain predictor checks each result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdg_pkg::*;

    localparam int      CYCLE_LIMIT = 200_000;
    localparam sample_t SAMPLE_MAX  = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN  = 24'sh800000;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    last;
    } stereo_frame_t;

    typedef enum logic [0:0] {ROW_FRAME, ROW_WRITE} row_kind_t;

    // One step of the directed sequence: a frame, or a register write.
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        int unsigned           value;
        stereo_frame_t         stim;
        bit                    typed;
        stereo_frame_t         want;
    } directed_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [FRAME_W-1:0]    s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [FRAME_W-1:0]    m_tdata;
    logic                  m_tlast;

    // Travels alongside s_tdata: a hand-written expectation for directed rows.
    bit                    use_typed = 1'b0;
    stereo_frame_t         typed_want;

    // Predictor state and its copy of the configuration.
    logic [FRAME_W-1:0]    frame_store [DELAY_DEPTH] = '{default: '0};
    int                    store_ptr  = 0;
    logic [DELAY_W-1:0]    delay_cfg  = DELAY_RESET;
    gain_t                 gain_cfg   = GAIN_RESET;

    stereo_frame_t         pending_outputs [$];
    directed_row_t         directed_rows [$];

    int                    burst_left      = 0;
    int                    frames_in       = 0;
    int                    results_checked = 0;
    int                    cfg_writes      = 0;
    int                    error_count     = 0;
    int                    cycle_count     = 0;
    logic [7:0]            ready_pattern   = 8'hFF;

    stereo_delay_and_gain DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scale by an unsigned Q2.14 gain with round half up, then clip to 24 bits.
    function automatic sample_t apply_gain(input sample_t s, input gain_t g);
        longint scaled;
        scaled = (longint'(s) * longint'(g) + 64'sd8192) >>> 14;
        if (scaled > 64'sd8388607) begin
            return SAMPLE_MAX;
        end else if (scaled < -64'sd8388608) begin
            return SAMPLE_MIN;
        end
        return SAMPLE_W'(scaled);
    endfunction

    // Advance the delay line by one frame and return the scaled output frame.
    function automatic stereo_frame_t delay_and_scale(input stereo_frame_t f);
        stereo_frame_t      y;
        logic [FRAME_W-1:0] old_frame;
        int                 span;
        int                 rd_idx;
        y = f;
        if (delay_cfg != 0) begin
            span = (delay_cfg > DELAY_DEPTH) ? DELAY_DEPTH : int'(delay_cfg);
            rd_idx = (store_ptr + DELAY_DEPTH - span) % DELAY_DEPTH;
            // Read before write, so a full-depth delay returns the oldest entry.
            old_frame = frame_store[rd_idx];
            frame_store[store_ptr] = {f.right, f.left};
            store_ptr = (store_ptr + 1) % DELAY_DEPTH;
            y.left  = old_frame[SAMPLE_W-1:0];
            y.right = old_frame[FRAME_W-1:SAMPLE_W];
        end
        y.left  = apply_gain(y.left, gain_cfg);
        y.right = apply_gain(y.right, gain_cfg);
        return y;
    endfunction

    // Mostly random samples, with the extremes, zero and minus one mixed in.
    function automatic sample_t random_sample();
        case ($urandom_range(0, 15))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic stereo_frame_t random_frame();
        stereo_frame_t f;
        f.left  = random_sample();
        f.right = random_sample();
        f.last  = 1'($urandom_range(0, 1));
        return f;
    endfunction

    function automatic void add_frame(input int l, input int r, input bit last);
        directed_row_t row;
        row = '{kind: ROW_FRAME, default: '0};
        row.kind = ROW_FRAME;
        row.stim = '{SAMPLE_W'(l), SAMPLE_W'(r), last};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input int l, input int r, input bit last,
                                        input int want_l, input int want_r);
        directed_row_t row;
        row = '{kind: ROW_FRAME, default: '0};
        row.kind  = ROW_FRAME;
        row.stim  = '{SAMPLE_W'(l), SAMPLE_W'(r), last};
        row.typed = 1'b1;
        row.want  = '{SAMPLE_W'(want_l), SAMPLE_W'(want_r), last};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        directed_row_t row;
        row = '{kind: ROW_WRITE, default: '0};
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = val;
        directed_rows.push_back(row);
    endfunction

    // Offer one frame; bursts of random length alternate with random gaps.
    task automatic send_frame(input stereo_frame_t f, input bit typed, input stereo_frame_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid   <= 1'b1;
        s_tdata    <= {f.right, f.left};
        s_tlast    <= f.last;
        use_typed  <= typed;
        typed_want <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the input side until every expected result has been seen. The first
    // edge lets the scoreboard record a transfer taken at the previous edge.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        if (idx == REG_DELAY_FRAMES) begin
            delay_cfg = DELAY_W'(val);
        end else if (idx == REG_GAIN) begin
            gain_cfg = GAIN_W'(val);
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    // Receiver backpressure: a random 8-bit ready pattern indexed by the cycle counter, which also times its re-draw.
    always @(posedge aclk) begin
        if (cycle_count % 256 == 0) begin
            ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
        m_tready <= ready_pattern[3'(cycle_count % 8)];
    end

    // Predict on each input transfer, check each output transfer against the oldest entry.
    always @(posedge aclk) begin : scoreboard
        stereo_frame_t accepted;
        stereo_frame_t want;
        stereo_frame_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                accepted.left  = s_tdata[SAMPLE_W-1:0];
                accepted.right = s_tdata[FRAME_W-1:SAMPLE_W];
                accepted.last  = s_tlast;
                want = delay_and_scale(accepted);
                if (use_typed) begin
                    want = typed_want;
                end
                pending_outputs.push_back(want);
                frames_in++;
            end
            if (m_tvalid && m_tready) begin
                got.left  = m_tdata[SAMPLE_W-1:0];
                got.right = m_tdata[FRAME_W-1:SAMPLE_W];
                got.last  = m_tlast;
                if (pending_outputs.size() == 0) begin
                    $error("unexpected result transfer: left %0d right %0d last %0b",
                           got.left, got.right, got.last);
                    error_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    results_checked++;
                    if (got.left !== want.left) begin
                        $error("left_out: expected %0d, got %0d", want.left, got.left);
                        error_count++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_out: expected %0d, got %0d", want.right, got.right);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("block_end_out: expected %0b, got %0b", want.last, got.last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, pending_outputs.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        stereo_frame_t no_frame;
        int            n;
        int            phase;
        int unsigned   pick;

        no_frame = '{default: '0};

        // Bypass at unity gain right after reset: frames come back unchanged.
        add_checked(0, 0, 1'b0, 0, 0);
        add_checked(8388607, -8388608, 1'b1, 8388607, -8388608);
        add_checked(-8388608, 8388607, 1'b0, -8388608, 8388607);
        add_checked(-1, 1, 1'b1, -1, 1);
        // Largest gain: full-scale input clips.
        add_write(REG_GAIN, 65535);
        add_checked(8388607, -8388608, 1'b0, 8388607, -8388608);
        add_frame(1, -1, 1'b1);
        add_checked(3000000, -3000000, 1'b0, 8388607, -8388608);
        // Zero gain mutes.
        add_write(REG_GAIN, 0);
        add_checked(8388607, -8388608, 1'b1, 0, 0);
        // Smallest nonzero gain and half gain exercise the rounding.
        add_write(REG_GAIN, 1);
        add_frame(8388607, -8388608, 1'b0);
        add_write(REG_GAIN, 8192);
        add_frame(1, -1, 1'b0);
        add_frame(3, -3, 1'b1);
        // One-frame delay: the first read hits an entry never written.
        add_write(REG_GAIN, 16384);
        add_write(REG_DELAY_FRAMES, 1);
        add_checked(100, 200, 1'b1, 0, 0);
        add_checked(300, 400, 1'b0, 100, 200);
        add_checked(-8388608, 8388607, 1'b1, 300, 400);
        add_write(REG_DELAY_FRAMES, 3);
        add_frame(11, -11, 1'b0);
        add_frame(22, -22, 1'b1);
        add_frame(33, -33, 1'b0);
        add_frame(44, -44, 1'b1);
        // Delays beyond the memory depth clamp to it.
        add_write(REG_DELAY_FRAMES, DELAY_DEPTH + 5);
        add_frame(55, -55, 1'b0);
        add_write(REG_DELAY_FRAMES, 262143);
        add_frame(-66, 66, 1'b1);
        // Back to bypass: memory and pointer stay put.
        add_write(REG_DELAY_FRAMES, 0);
        add_checked(5, 6, 1'b1, 5, 6);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_frame(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each with its own delay and gain setting.
        for (phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 9))
                0: pick = 0;
                1: pick = 1;
                2: pick = DELAY_DEPTH;
                3: pick = DELAY_DEPTH - 1;
                4: pick = 262143;
                5: pick = $urandom_range(0, 262143);
                default: pick = $urandom_range(1, 64);
            endcase
            write_reg(REG_DELAY_FRAMES, pick);
            case ($urandom_range(0, 5))
                0: pick = 0;
                1: pick = 65535;
                2: pick = 16384;
                default: pick = $urandom_range(0, 65535);
            endcase
            write_reg(REG_GAIN, pick);
            for (n = 0; n < 200; n++) begin
                if (n == 100 || $urandom_range(0, 199) == 0) begin
                    drain_results();
                end
                send_frame(random_frame(), 1'b0, no_frame);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);

        $display("Checked %0d results for %0d frame transfers across %0d register writes,",
                 results_checked, frames_in, cfg_writes);
        $display("including bypass, gain extremes, clamped delays and unwritten entries.");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
